@@ rtl/core/lbac_pkg.sv @@
// Shared constants, codes and types of the lagged bit autocorrelation block.
package lbac_pkg;

  localparam int MAX_LAG     = 256;
  localparam int COUNT_WIDTH = 32;

  localparam int KIND_W   = 2;
  localparam int LAG_W    = 9;
  localparam int CNT_O_W  = 32;
  localparam int CORR_W   = 33;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam int IDX_W = $clog2(MAX_LAG);
  localparam int GRP_W = IDX_W / 2;
  localparam int HI_W  = IDX_W - GRP_W;
  localparam int GRP   = 1 << GRP_W;
  localparam int NGRP  = 1 << HI_W;

  localparam int EXT_W = (COUNT_WIDTH + 2 > CORR_W) ? COUNT_WIDTH + 2 : CORR_W;
  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  localparam logic [CFG_W-1:0] PAIR_FLOOR_RST = 32'd1000;

  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PAIR_FLOOR = 1'b0;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic step;
    logic new_bit;
    logic last;
    logic clear;
  } lbac_ctrl_t;

endpackage

@@ rtl/core/lbac_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface lbac_in_if;
  logic                        valid;
  logic                        ready;
  logic [lbac_pkg::KIND_W-1:0] kind;
  logic                        data_bit;
  logic                        last_bit;
  logic [lbac_pkg::LAG_W-1:0]  query_lag;

  modport source (output valid, kind, data_bit, last_bit, query_lag, input ready);
  modport sink   (input valid, kind, data_bit, last_bit, query_lag, output ready);
endinterface

interface lbac_out_if;
  logic                          valid;
  logic                          ready;
  logic [lbac_pkg::LAG_W-1:0]    lag_echo;
  logic [lbac_pkg::CNT_O_W-1:0]  diff_count;
  logic [lbac_pkg::CNT_O_W-1:0]  pair_count;
  logic signed [lbac_pkg::CORR_W-1:0] corr_sum;
  logic                          eligible;

  modport source (output valid, lag_echo, diff_count, pair_count, corr_sum, eligible,
                  input ready);
  modport sink   (input valid, lag_echo, diff_count, pair_count, corr_sum, eligible,
                  output ready);
endinterface

@@ rtl/core/lbac_cell.sv @@
// One lag cell: history bit, in-sequence flag and the two saturating counters.
module lbac_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lbac_pkg::lbac_ctrl_t ctrl,
  input  logic                 hist_in,
  input  logic                 seq_in,
  output logic                 hist_o,
  output logic                 seq_o,
  output lbac_pkg::count_t     diff_o,
  output lbac_pkg::count_t     pair_o
);
  import lbac_pkg::*;

  logic   hist_r, hist_nxt;
  logic   seq_r, seq_nxt;
  count_t diff_r, diff_nxt;
  count_t pair_r, pair_nxt;

  always_comb begin
    hist_nxt = hist_r;
    seq_nxt  = seq_r;
    diff_nxt = diff_r;
    pair_nxt = pair_r;
    if (ctrl.step) begin
      if (seq_r) begin
        if (!(&pair_r)) pair_nxt = pair_r + 1'b1;
        if ((ctrl.new_bit != hist_r) && !(&diff_r)) diff_nxt = diff_r + 1'b1;
      end
      hist_nxt = hist_in;
      seq_nxt  = seq_in && !ctrl.last;
    end
    if (ctrl.clear) begin
      diff_nxt = '0;
      pair_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= 1'b0;
      seq_r  <= 1'b0;
      diff_r <= '0;
      pair_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      seq_r  <= seq_nxt;
      diff_r <= diff_nxt;
      pair_r <= pair_nxt;
    end
  end

  assign hist_o = hist_r;
  assign seq_o  = seq_r;
  assign diff_o = diff_r;
  assign pair_o = pair_r;

endmodule

@@ rtl/core/lbac_rdsel.sv @@
// Two-stage registered read tree over the cell counters, with the result register.
module lbac_rdsel (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    rd_req,
  input  logic [lbac_pkg::LAG_W-1:0]              query_lag,
  input  lbac_pkg::count_t [lbac_pkg::MAX_LAG-1:0] diff_all,
  input  lbac_pkg::count_t [lbac_pkg::MAX_LAG-1:0] pair_all,
  input  logic [lbac_pkg::CFG_W-1:0]              pair_floor,
  output logic                                    s1_free,
  lbac_out_if.source                              out_if
);
  import lbac_pkg::*;

  logic [LAG_W-1:0] idx_full;
  logic [GRP_W-1:0] lo;
  logic [HI_W-1:0]  hi;
  logic             ok;
  count_t [NGRP-1:0] gd, gp;

  logic              s1_valid_r;
  logic [LAG_W-1:0]  s1_lag_r;
  logic              s1_ok_r;
  logic [HI_W-1:0]   s1_hi_r;
  count_t [NGRP-1:0] s1_diff_r, s1_pair_r;

  count_t                  sel_d, sel_p;
  logic [EXT_W-1:0]        corr_ext;
  logic                    elig;

  logic                    out_valid_r;
  logic [LAG_W-1:0]        lag_r;
  logic [CNT_O_W-1:0]      diff_r, pair_r;
  logic [CORR_W-1:0]       corr_r;
  logic                    elig_r;

  logic out_adv, s1_adv;

  assign out_adv = !out_valid_r || out_if.ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign s1_free = s1_adv;

  assign idx_full = query_lag - LAG_W'(1);
  assign lo = idx_full[GRP_W-1:0];
  assign hi = idx_full[IDX_W-1:GRP_W];
  assign ok = (query_lag != '0) && (query_lag <= LAG_W'(MAX_LAG));

  // first level: pick the member inside every group
  always_comb begin
    gd = '0;
    gp = '0;
    for (int g = 0; g < NGRP; g++) begin
      for (int m = 0; m < GRP; m++) begin
        if (g * GRP + m < MAX_LAG) begin
          if (lo == GRP_W'(m)) begin
            gd[g] = diff_all[g * GRP + m];
            gp[g] = pair_all[g * GRP + m];
          end
        end
      end
    end
  end

  // second level: pick the group, then form the report
  always_comb begin
    sel_d    = s1_ok_r ? s1_diff_r[s1_hi_r] : '0;
    sel_p    = s1_ok_r ? s1_pair_r[s1_hi_r] : '0;
    corr_ext = EXT_W'(sel_p) - (EXT_W'(sel_d) << 1);
    elig     = s1_ok_r && (CMP_W'(sel_p) >= CMP_W'(pair_floor));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv)  s1_valid_r  <= rd_req;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && rd_req) begin
      s1_lag_r  <= query_lag;
      s1_ok_r   <= ok;
      s1_hi_r   <= hi;
      s1_diff_r <= gd;
      s1_pair_r <= gp;
    end
    if (out_adv && s1_valid_r) begin
      lag_r  <= s1_lag_r;
      diff_r <= CNT_O_W'(sel_d);
      pair_r <= CNT_O_W'(sel_p);
      corr_r <= corr_ext[CORR_W-1:0];
      elig_r <= elig;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.lag_echo   = lag_r;
  assign out_if.diff_count = diff_r;
  assign out_if.pair_count = pair_r;
  assign out_if.corr_sum   = $signed(corr_r);
  assign out_if.eligible   = elig_r;

endmodule

@@ rtl/core/lagged_bit_autocorrelation.sv @@
// Top level: APB register, chain of lag cells and the read tree.
//
//  channel  | dir | handshake              | payload
//  in_if    | in  | valid/ready            | kind, data_bit, last_bit, query_lag
//  out_if   | out | valid/ready            | lag_echo, diff_count, pair_count,
//           |     |                        | corr_sum, eligible
//  APB      | in  | psel/penable, pready=1 | paddr, pwdata, prdata (pair floor)
//
// One item per cycle while in_if.ready is high. A data bit updates every lag cell at
// its transfer edge. A read passes the tree stage and then the output register, which
// holds its result valid until the result transfers.
// Synchronous active-low reset clears history, sequence position, counters and the
// pair floor (1000). The output register and the tree stage let
// input transfers continue while one result waits; input stalls only when both hold.
module lagged_bit_autocorrelation (
  input  logic                               clk,
  input  logic                               rst_n,
  lbac_in_if.sink                            in_if,
  lbac_out_if.source                         out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lbac_pkg::PADDR_W-1:0]       paddr,
  input  logic [lbac_pkg::CFG_W-1:0]         pwdata,
  output logic [lbac_pkg::CFG_W-1:0]         prdata,
  output logic                               pready
);
  import lbac_pkg::*;

  logic [CFG_W-1:0]     pair_floor_r, pair_floor_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 in_take;
  logic                 s1_free;
  lbac_ctrl_t           ctrl;

  logic   [MAX_LAG-1:0] hist, seq;
  count_t [MAX_LAG-1:0] diff_all, pair_all;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_PAIR_FLOOR) ? pair_floor_r : '0;

  always_comb begin
    pair_floor_nxt = pair_floor_r;
    if (psel && penable && pwrite && (reg_idx == REG_PAIR_FLOOR))
      pair_floor_nxt = pwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_floor_r <= PAIR_FLOOR_RST;
    end else begin
      pair_floor_r <= pair_floor_nxt;
    end
  end

  assign in_if.ready = s1_free;
  assign in_take     = in_if.valid && s1_free;

  assign ctrl.step    = in_take && (in_if.kind == KIND_DATA);
  assign ctrl.clear   = in_take && (in_if.kind == KIND_CLEAR);
  assign ctrl.new_bit = in_if.data_bit;
  assign ctrl.last    = in_if.last_bit;

  for (genvar i = 0; i < MAX_LAG; i++) begin : g_cell
    logic h_in, s_in;
    if (i == 0) begin : g_head
      assign h_in = in_if.data_bit;
      assign s_in = 1'b1;
    end else begin : g_link
      assign h_in = hist[i-1];
      assign s_in = seq[i-1];
    end
    lbac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .hist_in (h_in),
      .seq_in  (s_in),
      .hist_o  (hist[i]),
      .seq_o   (seq[i]),
      .diff_o  (diff_all[i]),
      .pair_o  (pair_all[i])
    );
  end

  lbac_rdsel u_rdsel (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_req     (in_take && (in_if.kind == KIND_READ)),
    .query_lag  (in_if.query_lag),
    .diff_all   (diff_all),
    .pair_all   (pair_all),
    .pair_floor (pair_floor_r),
    .s1_free    (s1_free),
    .out_if     (out_if)
  );

endmodule
